// ===== rtl/wbs_pkg.sv =====
// shared types and constants for the word break segmenter
// used by wbs_match and word_break_segmenter_top; no dependencies
package wbs_pkg;

	localparam int MAX_WORDS    = 32;
	localparam int MAX_WORD_LEN = 8;

	// text window has a fixed size of eight bytes; verdict history holds nine verdicts, one more
	localparam int WIN_BYTES = 8;
	localparam int WIN_W     = 8 * WIN_BYTES;
	localparam int HIST_W    = WIN_BYTES + 1;

	localparam int WORD_W  = 8 * MAX_WORD_LEN;
	localparam int LEN_W   = $clog2(MAX_WORD_LEN + 2);
	localparam int IDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int COUNT_W = $clog2(MAX_WORDS + 1);

	typedef enum logic [1:0] {
		MODE_DICT  = 2'd0,
		MODE_TEXT  = 2'd1,
		MODE_CLEAR = 2'd2
	} wbs_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} wbs_state_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [WORD_W-1:0] chars;
	} word_entry_t;

endpackage

// ===== rtl/word_break_segmenter_top.sv =====
// word break segmenter: top level with word store, scan sequencer and output register
// depends on wbs_pkg and wbs_match
//
// usage
// - slave channel carries requests: s_tuser is the mode (dictionary byte, text byte,
//   clear), s_tdata the byte, s_tlast ends a dictionary word or a text string
// - dictionary bytes, clears and unused modes give no result; the block is ready again in
//   the next cycle
// - a text byte gives one result on the master channel: m_tdata bit 0 says the text
//   so far splits into stored words, bit 1 is the sticky dictionary overflow flag,
//   m_tlast copies the text byte's last flag
// - for a text byte the stored words are read from the word memory one per cycle through
//   a registered read port and checked by the single compare unit, then the result is
//   loaded; with an empty dictionary the scan is skipped; a match ends the scan early;
//   s_tready is low from acceptance until the result is loaded, so the block takes no
//   new request while a text byte is still being scanned or waits to load its result
// - the result sits in an output register; a new request is accepted while it waits,
//   but a text byte finishing while the register is still full holds until m_tready
// - after reset the dictionary is empty, the overflow flag clear and the text state at
//   its start (empty prefix splittable); no clearing pass is needed
module word_break_segmenter_top import wbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic [1:0] s_tuser,   // [1:0] mode
	input  logic       s_tlast,   // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [0] prefix_ok, [1] dictionary_overflow, [7:2] zero
	output logic       m_tlast    // end_of_text
);

	wbs_state_t state_q, state_d;

	word_entry_t word_mem [MAX_WORDS];

	logic [COUNT_W-1:0] word_count_q;
	logic [LEN_W-1:0]   load_len_q;
	logic [WORD_W-1:0]  pending_q;
	logic [WIN_W-1:0]   window_q;
	logic [HIST_W-1:0]  hist_q;
	logic               ovf_q;
	logic               last_q;
	logic               ok_q;

	logic [IDX_W-1:0]   rd_idx_q;
	logic               issue_q;
	word_entry_t        rd_entry_s1;
	logic               rd_vld_s1;
	logic               rd_last_s1;

	logic               m_tvalid_q;
	logic               m_ok_q;
	logic               m_ovf_q;
	logic               m_last_q;

	logic               in_acc;
	logic               hit;
	logic               issue_last;
	logic               scan_done;
	logic               out_load;

	logic               len_full;
	logic [LEN_W-1:0]   len_next;
	logic [WORD_W-1:0]  pend_next;
	logic               word_drop;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	assign len_full  = (load_len_q >= LEN_W'(MAX_WORD_LEN));
	assign len_next  = len_full ? LEN_W'(MAX_WORD_LEN + 1) : load_len_q + LEN_W'(1);
	assign pend_next = len_full ? pending_q : ((pending_q << 8) | WORD_W'(s_tdata));
	assign word_drop = (len_next > LEN_W'(MAX_WORD_LEN)) ||
	                   (word_count_q >= COUNT_W'(MAX_WORDS));

	assign issue_last = (COUNT_W'(rd_idx_q) == (word_count_q - COUNT_W'(1)));

	wbs_match u_match (
		.entry  (rd_entry_s1),
		.window (window_q),
		.hist   (hist_q),
		.hit    (hit)
	);

	assign scan_done = rd_vld_s1 && (hit || rd_last_s1);

	// sequencer
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (wbs_mode_t'(s_tuser) == MODE_TEXT)) begin
					state_d = (word_count_q == '0) ? ST_EMIT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// dictionary loading and text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			load_len_q   <= '0;
			pending_q    <= '0;
			window_q     <= '0;
			hist_q       <= HIST_W'(1);
			ovf_q        <= 1'b0;
		end else begin
			if (in_acc) begin
				case (wbs_mode_t'(s_tuser))
					MODE_DICT: begin
						if (s_tlast) begin
							if (word_drop) begin
								ovf_q <= 1'b1;
							end else begin
								word_count_q <= word_count_q + COUNT_W'(1);
							end
							pending_q  <= '0;
							load_len_q <= '0;
						end else begin
							pending_q  <= pend_next;
							load_len_q <= len_next;
						end
					end
					MODE_TEXT: begin
						window_q <= (window_q << 8) | WIN_W'(s_tdata);
					end
					MODE_CLEAR: begin
						word_count_q <= '0;
						load_len_q   <= '0;
						pending_q    <= '0;
						ovf_q        <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (out_load) begin
				if (last_q) begin
					window_q <= '0;
					hist_q   <= HIST_W'(1);
				end else begin
					hist_q <= {hist_q[HIST_W-2:0], ok_q};
				end
			end
		end
	end

	// word memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && (wbs_mode_t'(s_tuser) == MODE_DICT) && s_tlast && !word_drop) begin
			word_mem[word_count_q[IDX_W-1:0]] <= '{len: len_next, chars: pend_next};
		end
		rd_entry_s1 <= word_mem[rd_idx_q];
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == ST_SCAN) && issue_q && !scan_done;
			rd_last_s1 <= issue_last;
			if (state_q == ST_IDLE) begin
				rd_idx_q <= '0;
				issue_q  <= 1'b1;
			end else if (state_q == ST_SCAN) begin
				if (scan_done || issue_last) begin
					issue_q <= 1'b0;
				end
				if (issue_q && !issue_last) begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			last_q <= s_tlast;
			ok_q   <= 1'b0;
		end else if (scan_done) begin
			ok_q <= hit;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_ok_q   <= ok_q;
			m_ovf_q  <= ovf_q;
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_ovf_q, m_ok_q};
	assign m_tlast  = m_last_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= COUNT_W'(MAX_WORDS))
		else $error("word count beyond store depth");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_len_q <= LEN_W'(MAX_WORD_LEN + 1))
		else $error("loading length out of range");

	a_issue_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && issue_q |-> COUNT_W'(rd_idx_q) < word_count_q)
		else $error("scan reads past the stored words");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EMIT))
		else $error("result raised outside the emit step");

endmodule

// ===== rtl/wbs_match.sv =====
// compare unit: one stored word against the suffix of the text window
// depends on wbs_pkg
module wbs_match import wbs_pkg::*; (
	input  word_entry_t       entry,
	input  logic [WIN_W-1:0]  window,
	input  logic [HIST_W-1:0] hist,
	output logic              hit
);

	logic bytes_eq;
	logic start_ok;

	always_comb begin
		bytes_eq = 1'b1;
		start_ok = 1'b0;
		for (int b = 0; b < MAX_WORD_LEN; b++) begin
			// bytes beyond the word length are ignored
			if ((LEN_W'(b) < entry.len) && (window[8*b +: 8] != entry.chars[8*b +: 8])) begin
				bytes_eq = 1'b0;
			end
			// verdict at the position where the word would start
			if ((entry.len == LEN_W'(b + 1)) && hist[b]) begin
				start_ok = 1'b1;
			end
		end
	end

	assign hit = bytes_eq && start_ok;

endmodule
